@@ hw/rtl/mnep_pkg.sv @@
// ----------------------------------------------------------------------------
// mnep_pkg
// shared types, codes and small tables of the mml note event parser
// ----------------------------------------------------------------------------
package mnep_pkg;

  localparam int TIME_BITS   = 32;
  localparam int WHOLE_TICKS = 192;
  localparam int LOOP_LEAD   = 1;
  localparam int MAX_RESULTS = 4;
  localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);
  localparam int IDX_BITS    = $clog2(MAX_RESULTS);

  typedef logic [TIME_BITS-1:0] tick_t;

  // pending command codes
  typedef enum logic [4:0] {
    P_NONE  = 5'd0,
    P_M     = 5'd1,
    P_S     = 5'd2,
    P_T     = 5'd3,
    P_AT    = 5'd4,
    P_ATV   = 5'd5,
    P_Q     = 5'd6,
    P_V     = 5'd7,
    P_O     = 5'd8,
    P_LNUM  = 5'd9,
    P_LDOT  = 5'd10,
    P_RNUM  = 5'd11,
    P_RDOT  = 5'd12,
    P_NHEAD = 5'd13,
    P_NNUM  = 5'd14,
    P_NDOT  = 5'd15
  } pend_t;

  // event kinds
  typedef enum logic [3:0] {
    K_OFF   = 4'd0,
    K_ON    = 4'd1,
    K_TEMPO = 4'd2,
    K_TONE  = 4'd3,
    K_VOL   = 4'd4,
    K_ENVT  = 4'd5,
    K_ENVP  = 4'd6,
    K_LOOP  = 4'd7,
    K_END   = 4'd8
  } kind_t;

  typedef struct packed {
    logic [31:0] t;
    kind_t       kind;
    logic [7:0]  value;
    logic [15:0] wide;
  } evt_t;

  typedef struct packed {
    logic latch;
    logic div_start;
    logic mul;
    logic exec_main;
    logic exec_flush;
    logic start;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic absorbed;
    logic eot;
    logic more;
  } status_t;

  // semitone of note letters a..g
  function automatic logic [3:0] key_base(input logic [2:0] k);
    logic [3:0] r;
    case (k)
      3'd0:    r = 4'd9;
      3'd1:    r = 4'd11;
      3'd2:    r = 4'd0;
      3'd3:    r = 4'd2;
      3'd4:    r = 4'd4;
      3'd5:    r = 4'd5;
      3'd6:    r = 4'd7;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // plain volume v to extended volume v*8/3+85
  function automatic logic [7:0] vol_ext(input logic [3:0] v);
    logic [7:0] r;
    case (v)
      4'd0:    r = 8'd85;
      4'd1:    r = 8'd87;
      4'd2:    r = 8'd90;
      4'd3:    r = 8'd93;
      4'd4:    r = 8'd95;
      4'd5:    r = 8'd98;
      4'd6:    r = 8'd101;
      4'd7:    r = 8'd103;
      4'd8:    r = 8'd106;
      4'd9:    r = 8'd109;
      4'd10:   r = 8'd111;
      4'd11:   r = 8'd114;
      4'd12:   r = 8'd117;
      4'd13:   r = 8'd119;
      4'd14:   r = 8'd122;
      default: r = 8'd125;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] evt_time(input tick_t t);
    logic [63:0] w;
    w = 64'(t);
    return w[31:0];
  endfunction

endpackage

@@ hw/rtl/mnep_div.sv @@
// ----------------------------------------------------------------------------
// mnep_div
// restoring divider, whole-note ticks over a length number, one bit a cycle
// ----------------------------------------------------------------------------
module mnep_div (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] divisor,
  output logic [7:0] quo,
  output logic       done
);

  localparam logic [7:0] DIVIDEND = 8'(mnep_pkg::WHOLE_TICKS);

  logic       busy;
  logic [3:0] cnt;
  logic [7:0] rem;
  logic [8:0] sh;
  logic       ge;
  logic [2:0] bit_idx;

  assign bit_idx = 3'(cnt - 4'd1);
  assign sh      = {rem, DIVIDEND[bit_idx]};
  assign ge      = sh >= {1'b0, divisor};
  assign done    = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 4'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 4'd8;
    end else if (busy) begin
      cnt <= cnt - 4'd1;
      if (cnt == 4'd1) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= 8'd0;
      quo <= 8'd0;
    end else if (busy) begin
      rem <= ge ? 8'(sh - {1'b0, divisor}) : sh[7:0];
      quo <= {quo[6:0], ge};
    end
  end

endmodule

@@ hw/rtl/mnep_ctrl.sv @@
// ----------------------------------------------------------------------------
// mnep_ctrl
// sequencer: latch, divide, multiply, execute, start, drain results
// ----------------------------------------------------------------------------
module mnep_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  mnep_pkg::status_t  st,
  output mnep_pkg::cmd_t     cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PREP  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_EXEC  = 7'b0010000,
    S_START = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    phase_next = phase;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          phase_next = 1'b0;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        if (st.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_MUL;
        end
      end
      S_DIV: begin
        if (st.div_done) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!phase) begin
          cmd.exec_main = 1'b1;
          if (!st.absorbed) begin
            state_next = S_START;
          end else if (st.eot) begin
            phase_next = 1'b1;
            state_next = S_PREP;
          end else begin
            state_next = S_EMIT;
          end
        end else begin
          cmd.exec_flush = 1'b1;
          state_next     = S_EMIT;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        if (st.eot) begin
          phase_next = 1'b1;
          state_next = S_PREP;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        out_valid = st.more;
        cmd.pop   = st.more && out_ready;
        if (!st.more) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/mnep_dp.sv @@
// ----------------------------------------------------------------------------
// mnep_dp
// parser state, argument arithmetic, time keeping and result buffer
// ----------------------------------------------------------------------------
module mnep_dp (
  input  logic               clk,
  input  logic               rst,
  input  mnep_pkg::cmd_t     cmd,
  output mnep_pkg::status_t  st,
  input  logic [7:0]         chr_in,
  input  logic [15:0]        blen_in,
  input  logic               eot_in,
  output mnep_pkg::evt_t     evt,
  output logic               last
);

  localparam int MR = mnep_pkg::MAX_RESULTS;
  localparam int CB = mnep_pkg::CNT_BITS;
  localparam int IB = mnep_pkg::IDX_BITS;

  // latched input word
  logic [7:0]  chr;
  logic [15:0] blen;
  logic        eot;

  // parser state
  mnep_pkg::pend_t pend, pend_next;
  logic [15:0] acc, acc_next;
  logic        seen, seen_next;
  logic [1:0]  nmod, nmod_next;
  logic [15:0] dot, dot_next;
  logic [2:0]  nkey, nkey_next;
  logic [7:0]  octave, octave_next;
  logic [15:0] gate, gate_next;
  logic [15:0] deflen, deflen_next;
  logic [15:0] pvol, pvol_next;
  logic [15:0] evol, evol_next;
  logic [15:0] tempo, tempo_next;
  logic [15:0] tone, tone_next;
  mnep_pkg::tick_t cur, cur_next;
  mnep_pkg::tick_t bbase, bbase_next;

  // length stage
  logic [15:0] len_r, base_r;
  logic [31:0] prod_r;

  // result buffer
  mnep_pkg::evt_t rbuf [MR];
  mnep_pkg::evt_t rbuf_next [MR];
  logic [CB-1:0] cnt, cnt_next;
  logic [CB-1:0] rd, rd_next;

  // helpers
  logic [7:0]  lc;
  logic        dig;
  logic [3:0]  dv;
  logic [19:0] dmul;
  logic [15:0] digit_val;
  logic        indots, is_note;
  logic [15:0] base_len, len_c;
  logic [31:0] prod_c;
  logic [7:0]  quo;
  logic        div_done;
  logic        hit;

  // note pitch and gate
  logic [3:0]  kb, kb2;
  logic [9:0]  ot1, ot2;
  logic [7:0]  nkey_num;
  logic [28:0] tg;
  logic [15:0] ton;

  mnep_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .divisor (acc[7:0]),
    .quo     (quo),
    .done    (div_done)
  );

  assign lc  = (chr >= 8'h41 && chr <= 8'h5A) ? chr + 8'd32 : chr;
  assign dig = chr >= 8'h30 && chr <= 8'h39;
  assign dv  = 4'(chr - 8'h30);
  assign dmul = {1'b0, acc, 3'b0} + {3'b0, acc, 1'b0} + {16'd0, dv};
  assign digit_val = (dmul > 20'h0FFFF) ? 16'hFFFF : dmul[15:0];

  assign indots  = pend == mnep_pkg::P_LDOT || pend == mnep_pkg::P_RDOT ||
                   pend == mnep_pkg::P_NDOT;
  assign is_note = pend == mnep_pkg::P_NHEAD || pend == mnep_pkg::P_NNUM ||
                   pend == mnep_pkg::P_NDOT;

  assign base_len = !seen ? deflen :
                    (acc == 16'd0 || acc > 16'(mnep_pkg::WHOLE_TICKS)) ? 16'd0 :
                    {8'd0, quo};
  assign len_c  = indots ? acc : base_len;
  assign prod_c = len_c * gate;

  always_comb begin
    kb  = mnep_pkg::key_base(nkey);
    kb2 = kb;
    ot1 = {2'b0, octave};
    if (nmod == 2'd1) begin
      if (kb == 4'd11) begin
        kb2 = 4'd0;
        ot1 = ot1 + 10'd1;
      end else begin
        kb2 = kb + 4'd1;
      end
    end else if (nmod == 2'd2) begin
      if (kb == 4'd0) begin
        kb2 = 4'd11;
        ot1 = ot1 - 10'd1;
      end else begin
        kb2 = kb - 4'd1;
      end
    end
    ot2 = (ot1 != 10'd0) ? ot1 - 10'd1 : 10'd0;
    nkey_num = {4'd0, kb2} + 8'({ot2, 3'b0}) + 8'({ot2, 2'b0});
  end

  // on time of an untied note
  always_comb begin
    tg = prod_r[31:3];
    if (len_r <= 16'd1) begin
      ton = len_r;
    end else if (gate == 16'd8) begin
      ton = len_r - 16'd1;
    end else if (tg == 29'd0) begin
      ton = 16'd1;
    end else if (tg > {13'd0, len_r}) begin
      ton = len_r;
    end else begin
      ton = tg[15:0];
    end
  end

  function automatic mnep_pkg::evt_t mk(input mnep_pkg::tick_t t,
                                        input mnep_pkg::kind_t k,
                                        input logic [7:0] v,
                                        input logic [15:0] w);
    mnep_pkg::evt_t e;
    e.t     = mnep_pkg::evt_time(t);
    e.kind  = k;
    e.value = v;
    e.wide  = w;
    return e;
  endfunction

  // does the pending command take this byte
  always_comb begin
    hit = 1'b0;
    case (pend)
      mnep_pkg::P_NONE: hit = 1'b0;
      mnep_pkg::P_M:
        hit = dig || (!seen && (lc == 8'h62 || lc == 8'h66));
      mnep_pkg::P_AT:
        hit = dig || (!seen && lc == 8'h76);
      mnep_pkg::P_S, mnep_pkg::P_T, mnep_pkg::P_ATV, mnep_pkg::P_Q,
      mnep_pkg::P_V, mnep_pkg::P_O:
        hit = dig;
      default: begin
        if (is_note && chr == 8'h26) hit = 1'b1;
        else if (chr == 8'h2E) hit = 1'b1;
        else if (indots) hit = 1'b0;
        else if (pend == mnep_pkg::P_NHEAD &&
                 (chr == 8'h23 || chr == 8'h2B || chr == 8'h2D)) hit = 1'b1;
        else hit = dig;
      end
    endcase
  end

  always_comb begin
    mnep_pkg::evt_t ev [3];
    logic [1:0]  nev;
    logic        do_flush, do_note, tie, clr, end_ev;
    logic [15:0] pv, dsrc, asrc;
    logic [16:0] dsum;
    pend_next   = pend;
    acc_next    = acc;
    seen_next   = seen;
    nmod_next   = nmod;
    dot_next    = dot;
    nkey_next   = nkey;
    octave_next = octave;
    gate_next   = gate;
    deflen_next = deflen;
    pvol_next   = pvol;
    evol_next   = evol;
    tempo_next  = tempo;
    tone_next   = tone;
    cur_next    = cur;
    bbase_next  = bbase;
    rbuf_next   = rbuf;
    cnt_next    = cnt;
    rd_next     = rd;
    for (int i = 0; i < 3; i++) ev[i] = '0;
    nev      = 2'd0;
    do_flush = 1'b0;
    do_note  = 1'b0;
    tie      = 1'b0;
    clr      = 1'b0;
    end_ev   = 1'b0;
    pv       = seen ? acc : pvol;
    dsrc     = indots ? dot : base_r;
    asrc     = indots ? acc : base_r;
    dsum     = {1'b0, asrc} + {2'b0, dsrc[15:1]};

    if (cmd.latch) begin
      cnt_next = '0;
      rd_next  = '0;
    end

    if (cmd.exec_main && hit) begin
      case (pend)
        mnep_pkg::P_M, mnep_pkg::P_AT, mnep_pkg::P_S, mnep_pkg::P_T,
        mnep_pkg::P_ATV, mnep_pkg::P_Q, mnep_pkg::P_V, mnep_pkg::P_O: begin
          if (dig) begin
            acc_next  = digit_val;
            seen_next = 1'b1;
          end else if (pend == mnep_pkg::P_AT) begin
            pend_next = mnep_pkg::P_ATV;
          end else begin
            // mb or mf: skipped
            pend_next = mnep_pkg::P_NONE;
            clr       = 1'b1;
          end
        end
        default: begin
          if (is_note && chr == 8'h26) begin
            do_note   = 1'b1;
            tie       = 1'b1;
            pend_next = mnep_pkg::P_NONE;
            clr       = 1'b1;
          end else if (chr == 8'h2E) begin
            dot_next = {1'b0, dsrc[15:1]};
            acc_next = dsum[16] ? 16'hFFFF : dsum[15:0];
            if (pend == mnep_pkg::P_LNUM) pend_next = mnep_pkg::P_LDOT;
            else if (pend == mnep_pkg::P_RNUM) pend_next = mnep_pkg::P_RDOT;
            else if (is_note) pend_next = mnep_pkg::P_NDOT;
          end else if (pend == mnep_pkg::P_NHEAD && !dig) begin
            nmod_next = (chr == 8'h2D) ? 2'd2 : 2'd1;
            pend_next = mnep_pkg::P_NNUM;
          end else begin
            acc_next  = digit_val;
            seen_next = 1'b1;
            if (pend == mnep_pkg::P_NHEAD) pend_next = mnep_pkg::P_NNUM;
          end
        end
      endcase
    end

    if ((cmd.exec_main && !hit) || cmd.exec_flush) do_flush = 1'b1;
    if (cmd.exec_flush) end_ev = 1'b1;

    if (do_flush) begin
      case (pend)
        mnep_pkg::P_M: if (seen) begin
          ev[nev] = mk(cur, mnep_pkg::K_ENVP, 8'd0, acc);
          nev = nev + 2'd1;
        end
        mnep_pkg::P_S: if (seen) begin
          ev[nev] = mk(cur, mnep_pkg::K_ENVT, acc[7:0], 16'd0);
          nev = nev + 2'd1;
        end
        mnep_pkg::P_T: begin
          tempo_next = seen ? acc : tempo;
          ev[nev] = mk(cur, mnep_pkg::K_TEMPO, tempo_next[7:0], 16'd0);
          nev = nev + 2'd1;
        end
        mnep_pkg::P_AT: begin
          tone_next = seen ? acc : tone;
          ev[nev] = mk(cur, mnep_pkg::K_TONE, tone_next[7:0], 16'd0);
          nev = nev + 2'd1;
        end
        mnep_pkg::P_ATV: begin
          evol_next = seen ? acc : evol;
          ev[nev] = mk(cur, mnep_pkg::K_VOL, evol_next[7:0], 16'd0);
          nev = nev + 2'd1;
        end
        mnep_pkg::P_Q: if (seen) gate_next = acc;
        mnep_pkg::P_V: begin
          pvol_next = pv;
          if (pv > 16'd15) begin
            if (pv < 16'd128) begin
              ev[nev] = mk(cur, mnep_pkg::K_VOL, pv[7:0], 16'd0);
              nev = nev + 2'd1;
            end
          end else begin
            evol_next = {8'd0, mnep_pkg::vol_ext(pv[3:0])};
            ev[nev] = mk(cur, mnep_pkg::K_VOL, evol_next[7:0], 16'd0);
            nev = nev + 2'd1;
          end
        end
        mnep_pkg::P_O: if (seen) octave_next = (acc > 16'd255) ? 8'hFF : acc[7:0];
        mnep_pkg::P_LNUM, mnep_pkg::P_LDOT: deflen_next = len_r;
        mnep_pkg::P_RNUM, mnep_pkg::P_RDOT: begin
          ev[nev] = mk(cur, mnep_pkg::K_OFF, 8'd0, 16'd0);
          nev = nev + 2'd1;
          cur_next = cur + mnep_pkg::tick_t'(len_r);
        end
        mnep_pkg::P_NHEAD, mnep_pkg::P_NNUM, mnep_pkg::P_NDOT: do_note = 1'b1;
        default: ;
      endcase
      pend_next = mnep_pkg::P_NONE;
      clr       = 1'b1;
    end

    if (do_note) begin
      ev[nev] = mk(cur, mnep_pkg::K_ON, nkey_num, 16'd0);
      nev = nev + 2'd1;
      if (!tie && len_r > ton) begin
        ev[nev] = mk(cur + mnep_pkg::tick_t'(ton), mnep_pkg::K_OFF, nkey_num, 16'd0);
        nev = nev + 2'd1;
      end
      cur_next = cur + mnep_pkg::tick_t'(len_r);
    end

    if (end_ev) begin
      ev[nev] = mk(cur_next, mnep_pkg::K_END, 8'd0, 16'd0);
      nev = nev + 2'd1;
    end

    if (cmd.start) begin
      clr = 1'b1;
      case (lc)
        8'h6D: pend_next = mnep_pkg::P_M;
        8'h73: pend_next = mnep_pkg::P_S;
        8'h74: pend_next = mnep_pkg::P_T;
        8'h40: pend_next = mnep_pkg::P_AT;
        8'h71: pend_next = mnep_pkg::P_Q;
        8'h76: pend_next = mnep_pkg::P_V;
        8'h6F: pend_next = mnep_pkg::P_O;
        8'h6C: pend_next = mnep_pkg::P_LNUM;
        8'h72: pend_next = mnep_pkg::P_RNUM;
        8'h3E: octave_next = octave + 8'd1;
        8'h3C: octave_next = octave - 8'd1;
        8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67: begin
          nkey_next = 3'(lc - 8'h61);
          pend_next = mnep_pkg::P_NHEAD;
        end
        8'h7C: begin
          cur_next   = bbase + mnep_pkg::tick_t'(blen);
          bbase_next = cur_next;
        end
        8'h2A: begin
          cur_next   = bbase + mnep_pkg::tick_t'(blen) +
                       mnep_pkg::tick_t'(mnep_pkg::LOOP_LEAD);
          bbase_next = cur_next;
          ev[nev] = mk(cur_next, mnep_pkg::K_LOOP, 8'd0, 16'd0);
          nev = nev + 2'd1;
        end
        default: ;
      endcase
    end

    if (clr) begin
      acc_next  = 16'd0;
      seen_next = 1'b0;
      nmod_next = 2'd0;
      dot_next  = 16'd0;
    end

    // append, dropping anything past the buffer depth
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < nev && cnt_next < CB'(MR)) begin
        rbuf_next[cnt_next[IB-1:0]] = ev[i];
        cnt_next = cnt_next + CB'(1);
      end
    end

    if (cmd.pop) rd_next = rd + CB'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend   <= mnep_pkg::P_NONE;
      acc    <= 16'd0;
      seen   <= 1'b0;
      nmod   <= 2'd0;
      dot    <= 16'd0;
      nkey   <= 3'd0;
      octave <= 8'd5;
      gate   <= 16'd8;
      deflen <= 16'd48;
      pvol   <= 16'd8;
      evol   <= 16'd80;
      tempo  <= 16'd120;
      tone   <= 16'd0;
      cur    <= '0;
      bbase  <= '0;
      cnt    <= '0;
      rd     <= '0;
    end else begin
      pend   <= pend_next;
      acc    <= acc_next;
      seen   <= seen_next;
      nmod   <= nmod_next;
      dot    <= dot_next;
      nkey   <= nkey_next;
      octave <= octave_next;
      gate   <= gate_next;
      deflen <= deflen_next;
      pvol   <= pvol_next;
      evol   <= evol_next;
      tempo  <= tempo_next;
      tone   <= tone_next;
      cur    <= cur_next;
      bbase  <= bbase_next;
      cnt    <= cnt_next;
      rd     <= rd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      chr  <= chr_in;
      blen <= blen_in;
      eot  <= eot_in;
    end
    if (cmd.mul) begin
      len_r  <= len_c;
      base_r <= base_len;
      prod_r <= prod_c;
    end
    rbuf <= rbuf_next;
  end

  assign st.need_div = (pend == mnep_pkg::P_LNUM || pend == mnep_pkg::P_RNUM ||
                        pend == mnep_pkg::P_NHEAD || pend == mnep_pkg::P_NNUM) &&
                       seen && acc != 16'd0 &&
                       acc <= 16'(mnep_pkg::WHOLE_TICKS);
  assign st.div_done = div_done;
  assign st.absorbed = hit;
  assign st.eot      = eot;
  assign st.more     = rd < cnt;

  assign evt  = rbuf[rd[IB-1:0]];
  assign last = (rd + CB'(1)) == cnt;

endmodule

@@ hw/rtl/mml_note_event_parser_unit.sv @@
// ----------------------------------------------------------------------------
// mml_note_event_parser_unit
// streaming music macro language decoder producing timed note events
// ----------------------------------------------------------------------------
// one text byte per input word; a command runs when the first byte that
// cannot extend it arrives, or at the end-of-text flag (tlast), which also
// adds an end event. each input word gives zero to four result words, the
// final one marked by tlast; the event kind travels on tuser. an accepted
// input word passes through prepare, multiply and execute steps, plus a
// start step when it both closes one command and opens another, a second
// prepare, multiply and execute pass when end of text forces a second flush,
// and the bit-serial divider (whole note over the length number) on each of
// those passes where a numbered length is pending, before its result words
// drain and the unit returns to idle. input is taken only in idle; results
// drain from a four-entry buffer before the next byte is accepted
// ----------------------------------------------------------------------------
module mml_note_event_parser_unit (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // character[7:0], block_length[23:8]
  input  logic        s_axis_tlast,   // end_of_text
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // event_time[31:0], event_value[39:32],
                                      // event_wide_value[55:40]
  output logic [3:0]  m_axis_tuser,   // event_kind[3:0]
  output logic        m_axis_tlast    // last_of_run
);

  mnep_pkg::cmd_t    cmd;
  mnep_pkg::status_t st;
  mnep_pkg::evt_t    evt;

  // sequencer
  mnep_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // parser state and result buffer
  mnep_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .st      (st),
    .chr_in  (s_axis_tdata[7:0]),
    .blen_in (s_axis_tdata[23:8]),
    .eot_in  (s_axis_tlast),
    .evt     (evt),
    .last    (m_axis_tlast)
  );

  // pack result fields, lowest first
  assign m_axis_tdata = {evt.wide, evt.value, evt.t};
  assign m_axis_tuser = evt.kind;

endmodule

@@ verif/mml_note_event_parser_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mml_note_event_parser_unit_tb
// Feeds MML text to the parser, one byte per word, and checks every event
// word against an in-bench decoder. Text is mostly well-formed commands with
// random arguments, with some noise bytes mixed in. Idle and stall patterns
// change between phases.
// ----------------------------------------------------------------------------
module mml_note_event_parser_unit_tb;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // character[7:0], block_length[23:8]
  logic        s_axis_tlast;   // end_of_text
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;   // time[31:0], value[39:32], wide[55:40]
  logic [3:0]  m_axis_tuser;   // kind[3:0]
  logic        m_axis_tlast;   // last_of_run

  mml_note_event_parser_unit u_top (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  typedef struct {
    logic [7:0]  ch;
    logic [15:0] blen;
    logic        eot;
    logic        hold;     // wait until all events are back before sending
    int          phase;
  } text_word_t;

  typedef struct {
    logic [31:0]     t;
    mnep_pkg::kind_t kind;
    logic [7:0]      value;
    logic [15:0]     wide;
    logic            last;
  } event_t;

  text_word_t text_q[$];
  event_t     event_q[$];

  int n_words, n_events, n_loops, n_ends, n_errors;
  int cur_phase;

  // ---------------------------------------------------------------------------
  // decoder state
  // ---------------------------------------------------------------------------
  mnep_pkg::pend_t pend;
  int unsigned acc, dotl, note_key, octave, gate, def_len;
  int unsigned pvol, evol, tempo, tone;
  logic        seen;
  logic [1:0]  modf;          // 0 none, 1 sharp, 2 flat
  logic [31:0] now, blk_base;
  int          step_cnt;

  function void decoder_reset();
    pend = mnep_pkg::P_NONE; acc = 0; seen = 0; modf = 0; dotl = 0; note_key = 0;
    octave = 5; gate = 8; def_len = 48; pvol = 8; evol = 80; tempo = 120;
    tone = 0; now = 0; blk_base = 0;
  endfunction

  // at most four events per word, extra ones are dropped
  function void add_event(mnep_pkg::kind_t k, logic [31:0] t, int unsigned v,
                          int unsigned w);
    event_t e;
    if (step_cnt >= mnep_pkg::MAX_RESULTS) return;
    e.t = t; e.kind = k; e.value = v[7:0]; e.wide = w[15:0]; e.last = 1'b0;
    event_q = {event_q, e};
    step_cnt++;
  endfunction

  function void clear_args();
    acc = 0; seen = 0; modf = 0; dotl = 0;
  endfunction

  function void add_digit(int unsigned d);
    int unsigned v;
    v = acc * 10 + d;
    acc = (v > 65535) ? 65535 : v;
    seen = 1;
  endfunction

  function int unsigned base_len();
    if (!seen) return def_len;
    if (acc == 0 || acc > mnep_pkg::WHOLE_TICKS) return 0;
    return mnep_pkg::WHOLE_TICKS / acc;
  endfunction

  function bit in_dots();
    return pend == mnep_pkg::P_LDOT || pend == mnep_pkg::P_RDOT ||
           pend == mnep_pkg::P_NDOT;
  endfunction

  function int unsigned cur_len();
    return in_dots() ? acc : base_len();
  endfunction

  // each dot adds half of the previous addition
  function void add_dot();
    int unsigned v;
    if (!in_dots()) begin
      dotl = base_len();
      acc = dotl;
    end
    dotl = dotl >> 1;
    v = acc + dotl;
    acc = (v > 65535) ? 65535 : v;
  endfunction

  function void play_note(bit tie);
    int unsigned len, semi, ot, key, t_on;
    len = cur_len();
    case (note_key % 7)
      0: semi = 9;  1: semi = 11; 2: semi = 0; 3: semi = 2;
      4: semi = 4;  5: semi = 5;  default: semi = 7;
    endcase
    ot = octave;
    if (modf == 2'd1) begin
      if (semi == 11) begin semi = 0; ot++; end else semi++;
    end else if (modf == 2'd2) begin
      if (semi == 0) begin semi = 11; ot--; end else semi--;
    end
    if (ot != 0) ot--;
    key = (semi + ot * 12) & 8'hFF;
    if (tie || len <= 1) t_on = len;
    else if (gate == 8) t_on = len - 1;
    else begin
      t_on = (len * gate) >> 3;
      if (t_on == 0) t_on = 1;
      if (t_on > len) t_on = len;
    end
    add_event(mnep_pkg::K_ON, now, key, 0);
    // notes of length zero or one, tied notes and gates above 8 leave no note off
    if (len > t_on) add_event(mnep_pkg::K_OFF, now + t_on, key, 0);
    now = now + len;
  endfunction

  function void run_pending();
    case (pend)
      mnep_pkg::P_M:   if (seen) add_event(mnep_pkg::K_ENVP, now, 0, acc);
      mnep_pkg::P_S:   if (seen) add_event(mnep_pkg::K_ENVT, now, acc, 0);
      mnep_pkg::P_T: begin
        if (seen) tempo = acc;
        add_event(mnep_pkg::K_TEMPO, now, tempo, 0);
      end
      mnep_pkg::P_AT: begin
        if (seen) tone = acc;
        add_event(mnep_pkg::K_TONE, now, tone, 0);
      end
      mnep_pkg::P_ATV: begin
        if (seen) evol = acc;
        add_event(mnep_pkg::K_VOL, now, evol, 0);
      end
      mnep_pkg::P_Q:   if (seen) gate = acc;
      mnep_pkg::P_V: begin
        if (seen) pvol = acc;
        // loud plain volume passes through, 128 and up is dropped
        if (pvol > 15) begin
          if (pvol < 128) add_event(mnep_pkg::K_VOL, now, pvol, 0);
        end else begin
          evol = pvol * 8 / 3 + 85;
          add_event(mnep_pkg::K_VOL, now, evol, 0);
        end
      end
      mnep_pkg::P_O:   if (seen) octave = (acc > 255) ? 255 : acc;
      mnep_pkg::P_LNUM, mnep_pkg::P_LDOT: def_len = cur_len();
      mnep_pkg::P_RNUM, mnep_pkg::P_RDOT: begin
        int unsigned rlen;
        rlen = cur_len();
        add_event(mnep_pkg::K_OFF, now, 0, 0);
        now = now + rlen;
      end
      mnep_pkg::P_NHEAD, mnep_pkg::P_NNUM, mnep_pkg::P_NDOT: play_note(1'b0);
      default: ;
    endcase
    pend = mnep_pkg::P_NONE;
    clear_args();
  endfunction

  function logic [7:0] lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  // returns 1 when the byte extends the pending command
  function bit absorb(logic [7:0] c);
    logic [7:0] lc;
    bit dig, is_note;
    mnep_pkg::pend_t p;
    lc = lower(c);
    dig = c >= "0" && c <= "9";
    p = pend;
    is_note = p == mnep_pkg::P_NHEAD || p == mnep_pkg::P_NNUM ||
              p == mnep_pkg::P_NDOT;
    case (p)
      mnep_pkg::P_NONE: return 0;
      mnep_pkg::P_M: begin
        if (dig) begin add_digit(c - "0"); return 1; end
        // mb / mf are skipped
        if (!seen && (lc == "b" || lc == "f")) begin
          pend = mnep_pkg::P_NONE; clear_args(); return 1;
        end
        return 0;
      end
      mnep_pkg::P_AT: begin
        if (!seen && lc == "v") begin pend = mnep_pkg::P_ATV; return 1; end
        if (dig) begin add_digit(c - "0"); return 1; end
        return 0;
      end
      mnep_pkg::P_S, mnep_pkg::P_T, mnep_pkg::P_ATV, mnep_pkg::P_Q,
      mnep_pkg::P_V, mnep_pkg::P_O: begin
        if (dig) begin add_digit(c - "0"); return 1; end
        return 0;
      end
      default: ;
    endcase
    if (is_note && c == "&") begin
      play_note(1'b1);
      pend = mnep_pkg::P_NONE;
      clear_args();
      return 1;
    end
    if (c == ".") begin
      add_dot();
      if (p == mnep_pkg::P_LNUM) pend = mnep_pkg::P_LDOT;
      else if (p == mnep_pkg::P_RNUM) pend = mnep_pkg::P_RDOT;
      else if (is_note) pend = mnep_pkg::P_NDOT;
      return 1;
    end
    if (in_dots()) return 0;
    if (p == mnep_pkg::P_NHEAD && (c == "#" || c == "+" || c == "-")) begin
      modf = (c == "-") ? 2'd2 : 2'd1;
      pend = mnep_pkg::P_NNUM;
      return 1;
    end
    if (dig) begin
      add_digit(c - "0");
      if (p == mnep_pkg::P_NHEAD) pend = mnep_pkg::P_NNUM;
      return 1;
    end
    return 0;
  endfunction

  function void open_command(logic [7:0] c, logic [15:0] blen);
    logic [7:0] lc;
    lc = lower(c);
    clear_args();
    case (lc)
      "m": pend = mnep_pkg::P_M;
      "s": pend = mnep_pkg::P_S;
      "t": pend = mnep_pkg::P_T;
      "@": pend = mnep_pkg::P_AT;
      "q": pend = mnep_pkg::P_Q;
      "v": pend = mnep_pkg::P_V;
      "o": pend = mnep_pkg::P_O;
      "l": pend = mnep_pkg::P_LNUM;
      "r": pend = mnep_pkg::P_RNUM;
      ">": octave = (octave + 1) & 8'hFF;
      "<": octave = (octave - 1) & 8'hFF;
      "a", "b", "c", "d", "e", "f", "g": begin
        note_key = lc - "a";
        pend = mnep_pkg::P_NHEAD;
      end
      // block separator aligns time to the block end
      "|": begin
        now = blk_base + blen;
        blk_base = now;
      end
      "*": begin
        now = blk_base + blen + mnep_pkg::LOOP_LEAD;
        blk_base = now;
        add_event(mnep_pkg::K_LOOP, now, 0, 0);
      end
      default: ;
    endcase
  endfunction

  function void decode_word(text_word_t w);
    step_cnt = 0;
    if (!absorb(w.ch)) begin
      run_pending();
      open_command(w.ch, w.blen);
    end
    if (w.eot) begin
      run_pending();
      add_event(mnep_pkg::K_END, now, 0, 0);
    end
    if (step_cnt > 0) event_q[event_q.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // text generation
  // ---------------------------------------------------------------------------
  int n_queued;

  function int phase_of(int n);
    if (n < 120) return 0;
    if (n < 220) return 1;
    if (n < 320) return 2;
    return 3;
  endfunction

  function void push_byte(logic [7:0] c, logic eot);
    text_word_t w;
    int r;
    w.ch = c;
    r = $urandom_range(9, 0);
    w.blen = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom_range(65535, 0));
    w.eot = eot;
    w.phase = phase_of(n_queued);
    // drain fully before each of the stall-heavy phases begins
    w.hold = (n_queued == 220) || (n_queued == 320);
    text_q = {text_q, w};
    n_queued++;
  endfunction

  function void push_text(string s, logic eot_at_end);
    for (int i = 0; i < s.len(); i++)
      push_byte(s[i], eot_at_end && i == s.len() - 1);
  endfunction

  function string rand_length_num();
    int r;
    r = $urandom_range(11, 0);
    case (r)
      0: return "0";
      1: return "192";
      2: return "193";
      3: return "99999";
      4: return "1";
      5: return "3";
      default: return $sformatf("%0d", 1 << $urandom_range(5, 1));
    endcase
  endfunction

  function string rand_dots();
    string s;
    s = "";
    repeat ($urandom_range(3, 0) == 0 ? $urandom_range(4, 1) : 0) s = {s, "."};
    return s;
  endfunction

  function string rand_value(int hi);
    int r;
    r = $urandom_range(7, 0);
    if (r == 0) return "";
    if (r == 1) return "70000";
    return $sformatf("%0d", $urandom_range(hi, 0));
  endfunction

  function void push_command();
    string s, letters;
    int r, li;
    letters = "abcdefgABCDEFG";
    r = $urandom_range(19, 0);
    case (r)
      0, 1, 2, 3, 4, 5: begin
        li = $urandom_range(13, 0);
        s = letters.substr(li, li);
        case ($urandom_range(3, 0))
          0: s = {s, "#"};
          1: s = {s, "-"};
          2: s = {s, "+"};
          default: ;
        endcase
        if ($urandom_range(1, 0)) s = {s, rand_length_num()};
        s = {s, rand_dots()};
        if ($urandom_range(4, 0) == 0) s = {s, "&"};
      end
      6, 7: s = {($urandom_range(1, 0) ? "r" : "R"),
                 ($urandom_range(1, 0) ? rand_length_num() : ""), rand_dots()};
      8:  s = {"l", rand_length_num(), rand_dots()};
      9:  s = {"q", rand_value(10)};
      10: s = {"o", ($urandom_range(5, 0) == 0 ? "300" : rand_value(9))};
      11: s = {"V", ($urandom_range(3, 0) == 0 ? "128" : rand_value(20))};
      12: s = {"@v", rand_value(255)};
      13: s = {"@", rand_value(300)};
      14: s = {"t", rand_value(300)};
      15: s = {"s", rand_value(16)};
      16: s = {"m", ($urandom_range(2, 0) == 0 ? ($urandom_range(1, 0) ? "B" : "f")
                                              : rand_value(65535))};
      17: s = ($urandom_range(1, 0)) ? ">" : "<";
      18: s = ($urandom_range(1, 0)) ? "|" : "*";
      default: begin
        s = " ";
        s.putc(0, 8'($urandom_range(255, 1)));
      end
    endcase
    push_text(s, $urandom_range(29, 0) == 0);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one byte per word from text_q
  // ---------------------------------------------------------------------------
  text_word_t cur_word;

  function bit sender_idle(int ph);
    int pct;
    pct = (ph == 1) ? 88 : (ph == 3) ? 27 : 0;
    return $urandom_range(99, 0) < pct;
  endfunction

  always @(posedge clk) begin
    text_word_t w;
    bit fire;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
    end else begin
      fire = s_axis_tvalid && s_axis_tready;
      if (fire) begin
        decode_word(cur_word);
        n_words++;
        cur_phase = cur_word.phase;
      end
      if (!s_axis_tvalid || fire) begin
        if (text_q.size() != 0 && !(text_q[0].hold && event_q.size() != 0) &&
            !sender_idle(text_q[0].phase)) begin
          w = text_q.pop_front();
          cur_word = w;
          s_axis_tdata  <= {w.blen, w.ch};
          s_axis_tlast  <= w.eot;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compare each event word with the oldest expected one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    event_t e;
    int pct;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_events++;
        if (event_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected event word %h kind %0d last %b",
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end else begin
          e = event_q.pop_front();
          if (e.kind == mnep_pkg::K_LOOP) n_loops++;
          if (e.kind == mnep_pkg::K_END) n_ends++;
          if (m_axis_tdata[31:0] !== e.t || m_axis_tuser !== e.kind ||
              m_axis_tdata[39:32] !== e.value || m_axis_tdata[55:40] !== e.wide ||
              m_axis_tlast !== e.last) begin
            n_errors++;
            if (n_errors <= 10)
              $display({"event mismatch: exp t=%0d kind=%s val=%0d wide=%0d last=%b",
                        " / got t=%0d kind=%0d val=%0d wide=%0d last=%b"},
                       e.t, e.kind.name(), e.value, e.wide, e.last,
                       m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[39:32],
                       m_axis_tdata[55:40], m_axis_tlast);
          end
        end
      end
      pct = (cur_phase == 2) ? 88 : (cur_phase == 3) ? 27 : 0;
      m_axis_tready <= ($urandom_range(99, 0) >= pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    n_words = 0; n_events = 0; n_loops = 0; n_ends = 0; n_errors = 0;
    n_queued = 0; cur_phase = 0;
    decoder_reset();
    // directed: octave edges, flat c, loud volume, gate extremes, dots, tie,
    // zero length, separators and a final flush at end of text
    push_text("o0c-V15q9b+193..&Q0g1l0R*|mbT", 1'b1);
    while (n_queued < 410) push_command();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (text_q.size() != 0 || s_axis_tvalid || event_q.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d text words, checked %0d event words (%0d loop marks, %0d ends)",
             n_words, n_events, n_loops, n_ends);
    $display("phases: free flow, sparse input, stalled output, mixed idling");
    if (n_errors == 0 && event_q.size() == 0) begin
      $display("mml_note_event_parser_unit_tb OK");
    end else begin
      $display("%0d mismatches, %0d events missing", n_errors, event_q.size());
      $display("mml_note_event_parser_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("mml_note_event_parser_unit_tb NOT OK");
    $finish;
  end

endmodule
